/* sv/dtcrm_pkg.sv */
package dtcrm_pkg;

    // Instruction codes carried in iot_op.
    typedef enum logic [2:0] {
        IOT_READ_A       = 3'd0,
        IOT_CLEAR_A      = 3'd1,
        IOT_LOAD_A       = 3'd2,
        IOT_CLEAR_LOAD_A = 3'd3,
        IOT_SKIP         = 3'd4,
        IOT_READ_B       = 3'd5,
        IOT_SKIP_READ_B  = 3'd6,
        IOT_LOAD_B       = 3'd7
    } t_iot_op;

    // Item kinds carried in cmd.
    localparam logic CMD_IOT  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_DRIVE_LOADED    = 1'b0;
    localparam logic CFG_DRIVE_READ_ONLY = 1'b1;

    // Tape functions in status A bits 5..3.
    localparam logic [2:0] FN_MOVE   = 3'd0;
    localparam logic [2:0] FN_SEARCH = 3'd1;
    localparam logic [2:0] FN_READ   = 3'd2;
    localparam logic [2:0] FN_WRITE  = 3'd4;

    // Status bit masks.
    localparam logic [11:0] MASK_LOAD  = 12'o7774;
    localparam logic [11:0] MASK_BKEEP = 12'o7707;
    localparam logic [11:0] MASK_FIELD = 12'o0070;
    localparam logic [11:0] ST_ENDTAPE = 12'o5000;
    localparam logic [11:0] ST_SELERR  = 12'o4400;
    localparam logic [11:0] ST_INTREQ  = 12'o4001;
    localparam logic [11:0] ST_ERRBITS = 12'o7700;
    localparam logic [11:0] ST_DONE    = 12'o0001;
    localparam logic [11:0] MASK_12    = 12'o7777;

    localparam int unsigned BIT_REV  = 8;
    localparam int unsigned BIT_GO   = 7;
    localparam int unsigned BIT_CONT = 6;
    localparam int unsigned BIT_IENA = 2;

    typedef struct packed {
        logic        cmd;
        t_iot_op     iot_op;
        logic [11:0] ac_in;
        logic        link_in;
        logic [11:0] word_count_in;
    } t_in_item;

    typedef struct packed {
        logic [11:0] ac_out;
        logic        link_out;
        logic        skip;
        logic        irq;
        logic        block_valid;
        logic [10:0] block_number;
        logic [11:0] word_count_out;
        logic        done_res;
    } t_out_item;

    // Controller state held in flip-flops.
    typedef struct packed {
        logic [11:0] cmd_status;
        logic [11:0] err_status;
        logic        active;
    } t_ctl_state;

    // Mark distance for one step, indexed by the position within a block.
    function automatic logic [2:0] step_dist(input logic rev, input logic xfer,
                                             input logic [1:0] ph);
        logic [2:0] d;
        begin
            d = 3'd1;
            case ({rev, xfer, ph})
                4'b0000: d = 3'd1;
                4'b0001: d = 3'd4;
                4'b0010: d = 3'd3;
                4'b0011: d = 3'd2;
                4'b0100: d = 3'd2;
                4'b0101: d = 3'd1;
                4'b0110: d = 3'd4;
                4'b0111: d = 3'd3;
                4'b1000: d = 3'd2;
                4'b1001: d = 3'd3;
                4'b1010: d = 3'd4;
                4'b1011: d = 3'd1;
                4'b1100: d = 3'd3;
                4'b1101: d = 3'd4;
                4'b1110: d = 3'd1;
                4'b1111: d = 3'd2;
                default: d = 3'd1;
            endcase
            return d;
        end
    endfunction

endpackage

/* sv/dtcrm_pos_mem.sv */
module dtcrm_pos_mem import dtcrm_pkg::*; #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [12:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [12:0]   i_wr_data
);

    logic [12:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    logic [12:0]      r_rd_data;

    // Entry storage, no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Written flags; an entry never written reads as the start of tape.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read, with the same-cycle write forwarded to the reader.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_written[i_rd_addr] && i_rst_n) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/dtcrm_exec.sv */
module dtcrm_exec import dtcrm_pkg::*; #(
    parameter int unsigned BLOCKS_PER_TAPE = 1474,
    parameter int unsigned WORDS_PER_BLOCK = 129,
    parameter int unsigned NUM_DRIVES      = 8
) (
    input  t_in_item   i_item,
    input  t_ctl_state i_state,
    input  logic [12:0] i_pos,
    input  logic [7:0] i_drive_loaded,
    input  logic [7:0] i_drive_read_only,
    output t_ctl_state o_state,
    output t_out_item  o_item,
    output logic       o_pos_we,
    output logic [12:0] o_pos_wdata
);

    localparam logic [13:0] TAPE_END = 14'(BLOCKS_PER_TAPE * 4);
    localparam logic [12:0] WPB      = 13'(WORDS_PER_BLOCK);
    localparam logic [3:0]  NDRV     = 4'(NUM_DRIVES);

    logic [11:0] sa;
    logic [11:0] sb;
    logic        act;
    logic [11:0] ac;
    logic [11:0] wc;
    logic        skip;
    logic        bvalid;
    logic [10:0] bnum;
    logic        done;
    logic        hit;
    logic [2:0]  drv;
    logic [2:0]  fn;
    logic        xfer;
    logic        rev;
    logic        bad_sel;
    logic [2:0]  step_len;
    logic [13:0] fwd_pos;
    logic [12:0] new_pos;
    logic        eot;
    logic [12:0] left;
    logic [12:0] nwords;

    always_comb begin
        sa          = i_state.cmd_status;
        sb          = i_state.err_status;
        act         = i_state.active;
        ac          = i_item.ac_in;
        wc          = i_item.word_count_in;
        skip        = 1'b0;
        bvalid      = 1'b0;
        bnum        = '0;
        done        = 1'b0;
        hit         = |(i_state.err_status & ST_INTREQ);
        o_pos_we    = 1'b0;
        o_pos_wdata = i_pos;

        drv     = i_state.cmd_status[11:9];
        fn      = i_state.cmd_status[5:3];
        rev     = i_state.cmd_status[BIT_REV];
        xfer    = (fn >= FN_READ);
        bad_sel = ({1'b0, drv} >= NDRV) || !i_drive_loaded[drv]
                  || !((fn == FN_MOVE) || (fn == FN_SEARCH) || (fn == FN_READ)
                       || (fn == FN_WRITE))
                  || ((fn == FN_WRITE) && i_drive_read_only[drv]);

        // One mark group of tape motion, clamped at either end.
        step_len = step_dist(rev, xfer, i_pos[1:0]);
        fwd_pos  = {1'b0, i_pos} + {11'd0, step_len};
        eot      = 1'b0;
        if (rev) begin
            if (i_pos <= (xfer ? 13'd1 : 13'd2)) begin
                new_pos = '0;
                eot     = 1'b1;
            end else begin
                new_pos = i_pos - {10'd0, step_len};
            end
        end else if (fwd_pos >= TAPE_END) begin
            new_pos = 13'(TAPE_END - 14'd1);
            eot     = 1'b1;
        end else begin
            new_pos = fwd_pos[12:0];
        end

        // Words left before the count wraps; a count of zero leaves 4096.
        left   = 13'd4096 - {1'b0, i_item.word_count_in};
        nwords = (left < WPB) ? left : WPB;

        if (i_item.cmd == CMD_IOT) begin
            case (i_item.iot_op)
                IOT_READ_A: ac = ac | sa;
                IOT_CLEAR_A: begin
                    sa  = '0;
                    act = 1'b0;
                end
                IOT_LOAD_A, IOT_CLEAR_LOAD_A: begin
                    if (i_item.iot_op == IOT_CLEAR_LOAD_A) begin
                        sa = '0;
                    end
                    sa = sa ^ (ac & MASK_LOAD);
                    if (!ac[0]) begin
                        sb = sb & ~ST_DONE;
                    end
                    if (!ac[1]) begin
                        sb = sb & ~ST_ERRBITS;
                    end
                    act = sa[BIT_GO];
                    ac  = '0;
                end
                IOT_SKIP: skip = hit;
                IOT_READ_B: ac = ac | sb;
                IOT_SKIP_READ_B: begin
                    skip = hit;
                    ac   = ac | sb;
                end
                IOT_LOAD_B: begin
                    sb = (sb & MASK_BKEEP) | (ac & MASK_FIELD);
                    ac = '0;
                end
                default: ac = i_item.ac_in;
            endcase
        end else if (act) begin
            if (!sa[BIT_GO]) begin
                // Go bit dropped: the command ends quietly.
                act = 1'b0;
            end else if (bad_sel) begin
                sb   = sb | ST_SELERR;
                act  = 1'b0;
                done = 1'b1;
            end else begin
                o_pos_we    = 1'b1;
                o_pos_wdata = new_pos;
                if (eot) begin
                    sa[BIT_GO] = 1'b0;
                    sb   = sb | ST_ENDTAPE;
                    act  = 1'b0;
                    done = 1'b1;
                end else if (fn != FN_MOVE) begin
                    bvalid = 1'b1;
                    bnum   = new_pos[12:2];
                    if (fn == FN_SEARCH) begin
                        wc = wc + 12'd1;
                    end else begin
                        wc = wc + nwords[11:0];
                    end
                    if (!sa[BIT_CONT] || (wc == 12'd0)) begin
                        sb   = sb | ST_DONE;
                        act  = 1'b0;
                        done = 1'b1;
                    end
                end
            end
        end

        o_state.cmd_status = sa & MASK_12;
        o_state.err_status = sb;
        o_state.active     = act;

        o_item.ac_out         = ac;
        o_item.link_out       = i_item.link_in;
        o_item.skip           = skip;
        o_item.irq            = sa[BIT_IENA] && (|(sb & ST_INTREQ));
        o_item.block_valid    = bvalid;
        o_item.block_number   = bnum;
        o_item.word_count_out = wc;
        o_item.done_res       = done;
    end

endmodule

/* sv/dectape_controller_registers_motion_core.sv */
// Channel   Direction  Handshake                      Beat
// input     in         i_in_valid / o_in_ready        i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_ready      o_out_item (t_out_item)
// config    in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One beat is accepted per cycle while the output is not stalled; its result is offered
// from the output register. The tape position table is read at the accepting edge; a
// write from the beat ahead is forwarded into that read.
// Synchronous active-low reset clears the status registers and marks every tape
// position as the start of tape.
// A stalled output holds one result while one more beat waits in execution.
module dectape_controller_registers_motion_core import dtcrm_pkg::*; #(
    parameter int unsigned BLOCKS_PER_TAPE = 1474,
    parameter int unsigned WORDS_PER_BLOCK = 129,
    parameter int unsigned NUM_DRIVES      = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned AW = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

    logic [7:0] r_drive_loaded;
    logic [7:0] r_drive_read_only;
    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       r_ex_valid;
    t_in_item   r_ex_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;
    logic       ex_fire;
    logic       in_fire;
    logic [2:0] rd_drv;
    logic [12:0] pos_rd;
    logic       pos_we;
    logic [12:0] pos_wdata;

    // Handshake: execution moves when the output register is free or drained.
    assign ex_fire    = r_ex_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_ex_valid || ex_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // The next beat reads the drive selected by the state it will execute under.
    assign rd_drv = ex_fire ? n_state.cmd_status[11:9] : r_state.cmd_status[11:9];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_loaded    <= '0;
            r_drive_read_only <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRIVE_LOADED:    r_drive_loaded    <= i_cfg_data;
                CFG_DRIVE_READ_ONLY: r_drive_read_only <= i_cfg_data;
                default:             r_drive_loaded    <= r_drive_loaded;
            endcase
        end
    end

    dtcrm_pos_mem #(
        .DEPTH (NUM_DRIVES),
        .AW    (AW)
    ) u_pos_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_drv[AW-1:0]),
        .o_rd_data (pos_rd),
        .i_wr_en   (ex_fire && pos_we),
        .i_wr_addr (r_state.cmd_status[9+AW-1:9]),
        .i_wr_data (pos_wdata)
    );

    dtcrm_exec #(
        .BLOCKS_PER_TAPE (BLOCKS_PER_TAPE),
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .NUM_DRIVES      (NUM_DRIVES)
    ) u_exec (
        .i_item            (r_ex_item),
        .i_state           (r_state),
        .i_pos             (pos_rd),
        .i_drive_loaded    (r_drive_loaded),
        .i_drive_read_only (r_drive_read_only),
        .o_state           (n_state),
        .o_item            (n_out_item),
        .o_pos_we          (pos_we),
        .o_pos_wdata       (pos_wdata)
    );

    // Controller state and pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ex_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_ex_valid <= 1'b1;
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex_item <= i_in_item;
        end
        if (ex_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* sv/dtcrm_checker.sv */
module dtcrm_checker import dtcrm_pkg::*; #(
    parameter int unsigned BLOCKS_PER_TAPE = 1474
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    localparam logic [10:0] LAST_BLOCK = 11'(BLOCKS_PER_TAPE - 1);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Block fields are zero unless a block was reached, and stay on the tape.
    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.block_valid |-> o_out_item.block_number == 11'd0)
        else $error("block number without block");

    a_block_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.block_valid |-> o_out_item.block_number <= LAST_BLOCK)
        else $error("block number beyond tape end");

    // A skip comes only from an instruction, never together with tape events.
    a_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.skip |-> !o_out_item.block_valid && !o_out_item.done_res)
        else $error("skip together with tape event");

endmodule

bind dectape_controller_registers_motion_core dtcrm_checker #(
    .BLOCKS_PER_TAPE (BLOCKS_PER_TAPE)
) u_dtcrm_checker (.*);

/* sim/dectape_controller_registers_motion_core_tb.sv */
module dectape_controller_registers_motion_core_tb;
    import dtcrm_pkg::*;

    localparam int unsigned TAPE_BLOCKS   = 1474;
    localparam int unsigned WORDS_PER_BLK = 129;
    localparam int unsigned DRIVES        = 8;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned PHASES        = 7;
    localparam int unsigned PHASE_BEATS   = 64;
    localparam int unsigned SHOWN_ERRORS  = 40;

    // Receiver stall patterns.
    typedef enum {RX_OPEN, RX_RANDOM, RX_EVERY_FOURTH, RX_LONG_STALL} t_rx_mode;

    // Tracks controller state and holds the results each accepted beat must produce.
    class tape_scoreboard;
        logic [11:0] stat_a, stat_b;
        bit          busy;
        int unsigned head_pos [DRIVES];
        logic [7:0]  loaded_mask, locked_mask;
        logic [11:0] last_count;
        t_out_item   pending_q [$];
        int          errors, checked, blocks_seen, done_flags, sel_errors, tape_ends;
        int unsigned fwd_seek [4], fwd_xfer [4], rev_seek [4], rev_xfer [4];

        function new();
            fwd_seek = '{1, 4, 3, 2};
            fwd_xfer = '{2, 1, 4, 3};
            rev_seek = '{2, 3, 4, 1};
            rev_xfer = '{3, 4, 1, 2};
            stat_a = '0;
            stat_b = '0;
            busy = 0;
            loaded_mask = '0;
            locked_mask = '0;
            last_count = '0;
            foreach (head_pos[i]) head_pos[i] = 0;
        endfunction

        function void write_config(logic idx, logic [7:0] value);
            if (idx == CFG_DRIVE_LOADED) loaded_mask = value;
            else locked_mask = value;
        endfunction

        // Applies one accepted beat to the state and queues the result it causes.
        function void note_beat(t_in_item it);
            t_out_item   res;
            logic [11:0] acc, count;
            logic [2:0]  fn;
            bit          hit, xfer, eot;
            int unsigned drv, left, n;
            res = '0;
            acc = it.ac_in;
            count = it.word_count_in;
            if (it.cmd == CMD_IOT) begin
                hit = (stat_b & ST_INTREQ) != 0;
                case (it.iot_op)
                    IOT_READ_A: acc |= stat_a;
                    IOT_CLEAR_A: begin
                        stat_a = '0;
                        busy = 0;
                    end
                    IOT_LOAD_A, IOT_CLEAR_LOAD_A: begin
                        if (it.iot_op == IOT_CLEAR_LOAD_A) stat_a = '0;
                        stat_a ^= acc & MASK_LOAD;
                        if (!acc[0]) stat_b &= ~ST_DONE;
                        if (!acc[1]) stat_b &= ~ST_ERRBITS;
                        busy = stat_a[BIT_GO];
                        acc = '0;
                    end
                    IOT_SKIP: res.skip = hit;
                    IOT_READ_B: acc |= stat_b;
                    IOT_SKIP_READ_B: begin
                        res.skip = hit;
                        acc |= stat_b;
                    end
                    default: begin
                        stat_b = (stat_b & MASK_BKEEP) | (acc & MASK_FIELD);
                        acc = '0;
                    end
                endcase
            end else if (busy) begin
                drv = stat_a[11:9];
                fn = stat_a[5:3];
                if (!stat_a[BIT_GO]) begin
                    busy = 0;
                end else if (drv >= DRIVES || !loaded_mask[drv] ||
                             !(fn inside {FN_MOVE, FN_SEARCH, FN_READ, FN_WRITE}) ||
                             (fn == FN_WRITE && locked_mask[drv])) begin
                    stat_b |= ST_SELERR;
                    busy = 0;
                    res.done_res = 1;
                    sel_errors++;
                end else begin
                    // Move the head one mark group; transfers stop just after the data.
                    xfer = (fn == FN_READ || fn == FN_WRITE);
                    eot = 0;
                    if (stat_a[BIT_REV]) begin
                        if (head_pos[drv] <= (xfer ? 1 : 2)) begin
                            head_pos[drv] = 0;
                            eot = 1;
                        end else begin
                            head_pos[drv] -= xfer ? rev_xfer[head_pos[drv] % 4]
                                                  : rev_seek[head_pos[drv] % 4];
                        end
                    end else begin
                        head_pos[drv] += xfer ? fwd_xfer[head_pos[drv] % 4]
                                              : fwd_seek[head_pos[drv] % 4];
                        if (head_pos[drv] >= TAPE_BLOCKS * 4) begin
                            head_pos[drv] = TAPE_BLOCKS * 4 - 1;
                            eot = 1;
                        end
                    end
                    if (eot) begin
                        stat_a[BIT_GO] = 0;
                        stat_b |= ST_ENDTAPE;
                        busy = 0;
                        res.done_res = 1;
                        tape_ends++;
                    end else if (fn != FN_MOVE) begin
                        res.block_valid = 1;
                        res.block_number = 11'(head_pos[drv] / 4);
                        blocks_seen++;
                        if (fn == FN_SEARCH) begin
                            count = 12'(count + 1);
                        end else begin
                            // A zero count means the full 4096 words remain.
                            left = 4096 - count;
                            n = (left < WORDS_PER_BLK) ? left : WORDS_PER_BLK;
                            count = 12'(count + n);
                        end
                        if (!stat_a[BIT_CONT] || count == 0) begin
                            stat_b |= ST_DONE;
                            busy = 0;
                            res.done_res = 1;
                            done_flags++;
                        end
                    end
                end
            end
            res.ac_out = acc;
            res.link_out = it.link_in;
            res.irq = stat_a[BIT_IENA] && ((stat_b & ST_INTREQ) != 0);
            res.word_count_out = count;
            last_count = count;
            pending_q.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= SHOWN_ERRORS) $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [11:0] got, logic [11:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0o, should be %0o", checked, name, got, want));
        endtask

        // Compares one output beat with the oldest outstanding result.
        task check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                report("output beat arrived with no result outstanding");
                return;
            end
            want = pending_q.pop_front();
            checked++;
            compare_field("ac_out", got.ac_out, want.ac_out);
            compare_field("link_out", got.link_out, want.link_out);
            compare_field("skip", got.skip, want.skip);
            compare_field("irq", got.irq, want.irq);
            compare_field("block_valid", got.block_valid, want.block_valid);
            compare_field("block_number", got.block_number, want.block_number);
            compare_field("word_count_out", got.word_count_out, want.word_count_out);
            compare_field("done_res", got.done_res, want.done_res);
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    tape_scoreboard sb;
    int unsigned    cycles = 0;
    int unsigned    total_beats = 0;
    int unsigned    live_beats = 0;
    int unsigned    burst_left = 0;
    t_rx_mode       rx_mode = RX_OPEN;
    int unsigned    rx_left = 0;
    int unsigned    rx_stall = 0;
    int unsigned    rx_tick = 0;

    dectape_controller_registers_motion_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: picks a new stall pattern at random whenever the current one runs out.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN: i_out_ready = 1'b1;
            RX_RANDOM: i_out_ready = ($urandom_range(0, 99) < 70);
            RX_EVERY_FOURTH: i_out_ready = (rx_tick % 4 == 0);
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    i_out_ready = 1'b0;
                end else begin
                    i_out_ready = 1'b1;
                    if ($urandom_range(0, 4) == 0) rx_stall = $urandom_range(1, 16);
                end
            end
        endcase
    end

    // Output checking and the run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     sb.pending_q.size());
            $display("** dectape_controller_registers_motion_core: FAILED **");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
    end

    // Sends one beat; the sender works in random bursts separated by random gaps.
    task automatic send_beat(t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item = it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        total_beats++;
        if (it.cmd == CMD_IOT || sb.busy) live_beats++;
        sb.note_beat(it);
    endtask

    task automatic send_iot(t_iot_op op, logic [11:0] ac);
        t_in_item it;
        it.cmd = CMD_IOT;
        it.iot_op = op;
        it.ac_in = ac;
        it.link_in = 1'($urandom_range(0, 1));
        it.word_count_in = 12'($urandom_range(0, 4095));
        send_beat(it);
    endtask

    task automatic send_tick(logic [11:0] count);
        t_in_item it;
        it.cmd = CMD_TICK;
        it.iot_op = t_iot_op'($urandom_range(0, 7));
        it.ac_in = 12'($urandom_range(0, 4095));
        it.link_in = 1'($urandom_range(0, 1));
        it.word_count_in = count;
        send_beat(it);
    endtask

    function automatic logic [11:0] ctl_word(int unsigned drv, bit rev, bit go, bit cont,
                                             logic [2:0] fn, bit ien, logic [1:0] low);
        return {drv[2:0], rev, go, cont, fn, ien, low};
    endfunction

    // Drops valid and waits until every outstanding result has been delivered.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.write_config(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One tape command: load status A, then feed ticks while it runs,
    // returning the updated word count the way a host would.
    task automatic random_command();
        int unsigned drv, ticks, pick, k;
        bit          rev, cont;
        logic [2:0]  fn;
        logic [11:0] word, count;
        drv = $urandom_range(0, 7);
        rev = ($urandom_range(0, 9) < 3);
        cont = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        if (pick < 2) fn = FN_MOVE;
        else if (pick < 8) fn = FN_SEARCH;
        else if (pick < 13) fn = FN_READ;
        else if (pick < 17) fn = FN_WRITE;
        else fn = 3'($urandom_range(0, 7));
        word = ctl_word(drv, rev, $urandom_range(0, 9) != 0, cont, fn,
                        1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_iot(IOT_LOAD_A, word);
        end else if (pick == 1) begin
            send_iot(IOT_CLEAR_A, 12'($urandom_range(0, 4095)));
            send_iot(IOT_LOAD_A, word);
        end else begin
            send_iot(IOT_CLEAR_LOAD_A, word);
        end
        if (cont && fn == FN_SEARCH) count = 12'(4096 - $urandom_range(1, 12));
        else if (cont) count = 12'(4096 - $urandom_range(1, 700));
        else count = 12'($urandom_range(0, 4095));
        ticks = (fn == FN_MOVE) ? $urandom_range(1, 40) : $urandom_range(1, 12);
        k = 0;
        while (k < ticks && sb.busy) begin
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
                send_iot(t_iot_op'($urandom_range(4, 6)), 12'($urandom_range(0, 4095)));
            end else if (pick == 1) begin
                // Abort or restart the running command.
                send_iot(t_iot_op'($urandom_range(1, 3)), 12'($urandom_range(0, 4095)));
            end else begin
                send_tick(count);
                count = sb.last_count;
            end
            k++;
        end
        if ($urandom_range(0, 1)) send_iot(t_iot_op'($urandom_range(4, 6)), 12'o0);
        if ($urandom_range(0, 3) == 0) send_iot(IOT_READ_A, 12'($urandom_range(0, 4095)));
    endtask

    initial begin
        int unsigned phase, start, pick, k;
        logic [31:0] raw;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DRIVE_LOADED;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: drive 7 unmounted, drive 1 write locked.
        write_reg(CFG_DRIVE_LOADED, 8'h7F);
        write_reg(CFG_DRIVE_READ_ONLY, 8'h02);
        send_iot(IOT_READ_A, 12'o7777);
        send_iot(IOT_READ_B, 12'o0000);
        send_iot(IOT_SKIP, 12'o0000);
        send_iot(IOT_LOAD_B, 12'o7777);
        send_iot(IOT_SKIP_READ_B, 12'o0000);
        send_tick(12'o0000);
        // Reverse move from the tape start hits end of tape at once.
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(6, 1, 1, 0, FN_MOVE, 1, 2'b11));
        send_tick(12'o7777);
        send_iot(IOT_SKIP, 12'o0000);
        // Loading zero clears the done flag and the error bits.
        send_iot(IOT_LOAD_A, 12'o0000);
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(0, 0, 1, 0, FN_SEARCH, 1, 2'b11));
        send_tick(12'o7777);
        send_iot(IOT_SKIP_READ_B, 12'o0000);
        // Continuous read ending on a short last block, then one starting at zero.
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(0, 0, 1, 1, FN_READ, 0, 2'b10));
        send_tick(12'o7700);
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(0, 0, 1, 1, FN_READ, 1, 2'b11));
        send_tick(12'o0000);
        send_iot(IOT_CLEAR_A, 12'o0000);
        send_tick(12'o0201);
        // Select errors: write locked, unmounted drive, bad function.
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(1, 0, 1, 0, FN_WRITE, 1, 2'b11));
        send_tick(12'o0000);
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(7, 0, 1, 0, FN_SEARCH, 0, 2'b11));
        send_tick(12'o4000);
        send_iot(IOT_CLEAR_LOAD_A, ctl_word(0, 1, 1, 1, 3'd5, 1, 2'b11));
        send_tick(12'o0001);

        // Random part, one register setting per phase.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_DRIVE_LOADED, 8'hFF);
                    write_reg(CFG_DRIVE_READ_ONLY, 8'h00);
                end
                1: begin
                    write_reg(CFG_DRIVE_READ_ONLY, 8'hFF);
                    write_reg(CFG_DRIVE_LOADED, 8'hFF);
                end
                2: begin
                    write_reg(CFG_DRIVE_LOADED, 8'h00);
                    write_reg(CFG_DRIVE_READ_ONLY, 8'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(CFG_DRIVE_LOADED,
                              8'($urandom_range(0, 255) | $urandom_range(0, 255)));
                    write_reg(CFG_DRIVE_READ_ONLY,
                              8'($urandom_range(0, 255) & $urandom_range(0, 255)));
                end
            endcase
            if (phase == 0) begin
                // Run an untouched drive forward until it reaches the far tape end.
                send_iot(IOT_CLEAR_LOAD_A, ctl_word(3, 0, 1, 0, FN_MOVE, 1, 2'b11));
                k = 0;
                while (sb.busy && k < 1600) begin
                    send_tick(12'($urandom_range(0, 4095)));
                    k++;
                end
            end
            start = live_beats;
            while (live_beats - start < PHASE_BEATS) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    random_command();
                end else if (pick < 14) begin
                    send_iot(IOT_LOAD_B, 12'($urandom_range(0, 4095)));
                end else if (pick < 17) begin
                    raw = $urandom;
                    send_beat(raw[$bits(t_in_item)-1:0]);
                end else begin
                    send_iot(t_iot_op'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
                end
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d beats (%0d not idle ticks), checked %0d results, %0d mismatches.",
                 total_beats, live_beats, sb.checked, sb.errors);
        $display("Tape activity: %0d blocks, %0d done flags, %0d select errors, %0d tape ends.",
                 sb.blocks_seen, sb.done_flags, sb.sel_errors, sb.tape_ends);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("** dectape_controller_registers_motion_core: PASSED **");
        end else begin
            $display("** dectape_controller_registers_motion_core: FAILED **");
        end
        $finish;
    end

endmodule
